FILE: src/oma_pkg.sv
// ----------------------------------------------------------------------------
// oma_pkg: shared constants and types of the online moment accumulator
// Holds the parameter defaults, field widths and the fixed-point constants
// used by the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package oma_pkg;

    localparam int COUNT_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    localparam int SAMPLE_W = 32;
    localparam int WIDE_W   = 64;

    localparam logic [WIDE_W-1:0] SMAX = {1'b0, {(WIDE_W-1){1'b1}}};

    // Operation codes of the shared unit.
    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_DIV = 2'd1;
    localparam logic [1:0] OP_ROOT = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] op;
        logic [5:0] shift;
    } unit_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } unit_stat_t;

endpackage

FILE: src/oma_unit.sv
// ----------------------------------------------------------------------------
// oma_unit: shared iterative arithmetic unit
// Signed multiply with shift, truncation toward zero and clamp to +-(2^63-1)
// via a 16-bit radix step; unsigned 64 by 64 restoring division, one quotient
// bit a cycle; unsigned digit-by-digit square root of a 96-bit radicand, one
// root bit a cycle.
// ----------------------------------------------------------------------------
module oma_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  oma_pkg::unit_cmd_t    cmd,
    input  logic [63:0]           a,
    input  logic [63:0]           b,
    output oma_pkg::unit_stat_t   stat,
    output logic [63:0]           result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        sat_reg, sat_next;
    logic [1:0]  op_reg, op_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [5:0]  sh_reg, sh_next;
    logic        neg_reg, neg_next;
    logic [63:0] ma_reg, ma_next;
    logic [63:0] mb_reg, mb_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] res_reg, res_next;

    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [127:0] shifted;
    logic [63:0]  clamp_mag;
    logic         ovf_mul;
    logic [64:0]  div_trial;
    logic [63:0]  root_rem;
    logic [63:0]  root_trial;
    logic [64:0]  root_diff;
    logic [79:0]  part;

    always_comb begin
        mag_a = a[63] ? (64'd0 - a) : a;
        mag_b = b[63] ? (64'd0 - b) : b;
        shifted = acc_reg >> sh_reg;
        ovf_mul = (shifted[127:64] != 64'd0) || (shifted[63:0] > oma_pkg::SMAX);
        clamp_mag = ovf_mul ? oma_pkg::SMAX : shifted[63:0];
        div_trial = {rem_reg, ma_reg[63]} - {1'b0, mb_reg};
        root_rem = {rem_reg[61:0], acc_reg[95:94]};
        root_trial = {res_reg[61:0], 2'b01};
        root_diff = {1'b0, root_rem} - {1'b0, root_trial};
        part = ma_reg * {64'd0, mb_reg[15:0]};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        sat_next  = sat_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        neg_next  = neg_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        if (cmd.start && !busy_reg) begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            sh_next   = cmd.shift;
            sat_next  = 1'b0;
            res_next  = 64'd0;
            acc_next  = 128'd0;
            rem_next  = 64'd0;
            case (cmd.op)
                oma_pkg::OP_MUL: begin
                    neg_next = a[63] ^ b[63];
                    ma_next  = mag_a;
                    mb_next  = mag_b;
                    cnt_next = 7'd4;
                end
                oma_pkg::OP_DIV: begin
                    neg_next = 1'b0;
                    ma_next  = a;
                    mb_next  = b;
                    cnt_next = 7'd64;
                end
                default: begin
                    neg_next = 1'b0;
                    acc_next = {64'd0, a} << cmd.shift;
                    cnt_next = 7'd47;
                end
            endcase
        end else if (busy_reg) begin
            case (op_reg)
                oma_pkg::OP_MUL: begin
                    if (cnt_reg == 7'd0) begin
                        res_next  = neg_reg ? (64'd0 - clamp_mag) : clamp_mag;
                        sat_next  = ovf_mul;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end else begin
                        acc_next = acc_reg
                            + ({48'd0, part} << (7'd16 * (7'd4 - cnt_reg)));
                        mb_next  = mb_reg >> 16;
                        cnt_next = cnt_reg - 7'd1;
                    end
                end
                oma_pkg::OP_DIV: begin
                    if (!div_trial[64]) begin
                        rem_next = div_trial[63:0];
                        res_next = {res_reg[62:0], 1'b1};
                    end else begin
                        rem_next = {rem_reg[62:0], ma_reg[63]};
                        res_next = {res_reg[62:0], 1'b0};
                    end
                    ma_next  = {ma_reg[62:0], 1'b0};
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default: begin
                    if (!root_diff[64]) begin
                        rem_next = root_diff[63:0];
                        res_next = {res_reg[62:0], 1'b1};
                    end else begin
                        rem_next = root_rem;
                        res_next = {res_reg[62:0], 1'b0};
                    end
                    acc_next = acc_reg << 2;
                    cnt_next = cnt_reg - 7'd1;
                    if (cnt_reg == 7'd0) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        sat_reg <= sat_next;
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        neg_reg <= neg_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
    assign result    = res_reg;

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("unit done while busy");
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.start && !busy_reg) |=> busy_reg) else $error("unit did not start");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("done held");

endmodule

FILE: src/online_moment_accumulator.sv
// ----------------------------------------------------------------------------
// online_moment_accumulator: running count, mean, variance and moment sums
// Single-pass incremental statistics over signed Q8.24 samples.
// ----------------------------------------------------------------------------
// Each beat on the slave side is one sample; each produces one result beat.
// One sample is worked off by a sequencer over a single shared iterative unit:
// the count division, thirteen multiplies, the variance division and the square
// root, plus the accepting state and the state that loads the result register.
// While fewer than two samples have been seen the variance division and the
// square root are skipped; once the count is full only those two run. s_tready
// stays low until the sequencer is back in its idle state. The result waits in
// an output register until taken. A full count ignores samples and sets the
// sticky overflow flag; moment sums saturate at +-(2^63-1).
module online_moment_accumulator #(
    parameter int COUNT_BITS = oma_pkg::COUNT_BITS_DEF,
    parameter int FRAC_BITS  = oma_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,   // sample[31:0]
    output logic          m_tvalid,
    input  logic          m_tready,
    // count[31:0], running_mean[63:32], sample_variance[126:64],
    // std_deviation[170:127], variance_valid[171], third_moment_sum[235:172],
    // fourth_moment_sum[298:236], overflow[299], zero fill [303:300]
    output logic [303:0]  m_tdata
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_DIV  = 5'd1;
    localparam logic [4:0] ST_DN2  = 5'd2;
    localparam logic [4:0] ST_DDN  = 5'd3;
    localparam logic [4:0] ST_T1   = 5'd4;
    localparam logic [4:0] ST_A1   = 5'd5;
    localparam logic [4:0] ST_A2   = 5'd6;
    localparam logic [4:0] ST_B1   = 5'd7;
    localparam logic [4:0] ST_B2   = 5'd8;
    localparam logic [4:0] ST_C1   = 5'd9;
    localparam logic [4:0] ST_C2   = 5'd10;
    localparam logic [4:0] ST_E1   = 5'd11;
    localparam logic [4:0] ST_E2   = 5'd12;
    localparam logic [4:0] ST_F1   = 5'd13;
    localparam logic [4:0] ST_F2   = 5'd14;
    localparam logic [4:0] ST_VAR  = 5'd15;
    localparam logic [4:0] ST_ROOT = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    localparam logic [COUNT_BITS-1:0] FULL = {COUNT_BITS{1'b1}};
    localparam logic [5:0] FSH = 6'(FRAC_BITS);

    logic [4:0]            st_reg, st_next;
    logic                  issued_reg, issued_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [63:0]           mean_reg, mean_next;
    logic [63:0]           m2_reg, m2_next;
    logic [63:0]           m3_reg, m3_next;
    logic [63:0]           m4_reg, m4_next;
    logic                  sticky_reg, sticky_next;
    logic                  sat_reg, sat_next;
    logic [63:0]           d_reg, d_next;
    logic [63:0]           dn_reg, dn_next;
    logic [63:0]           dn2_reg, dn2_next;
    logic [63:0]           t1_reg, t1_next;
    logic [63:0]           tmp_reg, tmp_next;
    logic [63:0]           var_reg, var_next;
    logic [63:0]           sd_reg, sd_next;
    logic                  mv_reg, mv_next;
    logic [303:0]          out_reg, out_next;

    oma_pkg::unit_cmd_t    cmd;
    oma_pkg::unit_stat_t   ustat;
    logic [63:0]           ua, ub, ures;

    logic [63:0]           nw, n1w, poly, nm2;
    logic                  poly_sat;
    logic [31:0]           nlo;
    logic [63:0]           nsq;
    logic [63:0]           dmag, qsigned;
    logic [64:0]           sadd;
    logic [63:0]           sadd_res;
    logic                  sadd_sat;
    logic [63:0]           add_b;
    logic [64:0]           m2s;
    logic [63:0]           m2_res;
    logic                  m2_sat;

    oma_unit u_unit (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .a(ua), .b(ub),
        .stat(ustat), .result(ures)
    );

    always_comb begin
        n1w = 64'(cnt_reg);
        nw  = n1w + 64'd1;
        nm2 = nw - 64'd2;
        nlo = nw[31:0];
        nsq = 64'(nlo) * 64'(nlo);
        poly_sat = 1'b0;
        if (nw < 64'h1_0000_0000) begin
            poly = nsq - 64'd3 * nw + 64'd3;
            if (poly > oma_pkg::SMAX) begin
                poly = oma_pkg::SMAX;
                poly_sat = 1'b1;
            end
        end else begin
            poly = oma_pkg::SMAX;
            poly_sat = 1'b1;
        end
        dmag = d_reg[63] ? (64'd0 - d_reg) : d_reg;
        qsigned = d_reg[63] ? (64'd0 - ures) : ures;
        m2s = {m2_reg[63], m2_reg} + {t1_reg[63], t1_reg};
        m2_res = m2s[63:0];
        m2_sat = 1'b0;
        if (m2s[64] != m2s[63]) begin
            m2_sat = 1'b1;
            m2_res = m2s[64] ? (64'd0 - oma_pkg::SMAX) : oma_pkg::SMAX;
        end
    end

    // Saturating add of the finished product to the current accumulator.
    always_comb begin
        case (st_reg)
            ST_A2, ST_B2, ST_C2: add_b = m4_reg;
            ST_E2, ST_F2:        add_b = m3_reg;
            default:             add_b = m2_reg;
        endcase
        sadd = {add_b[63], add_b} + {ures[63], ures};
        sadd_sat = 1'b0;
        sadd_res = sadd[63:0];
        if (sadd[64] != sadd[63]) begin
            sadd_sat = 1'b1;
            sadd_res = sadd[64] ? (64'd0 - oma_pkg::SMAX) : oma_pkg::SMAX;
        end else if (sadd[63:0] == 64'h8000_0000_0000_0000) begin
            sadd_sat = 1'b1;
            sadd_res = 64'd0 - oma_pkg::SMAX;
        end
    end

    always_comb begin
        st_next = st_reg; issued_next = issued_reg; cnt_next = cnt_reg;
        mean_next = mean_reg; m2_next = m2_reg; m3_next = m3_reg; m4_next = m4_reg;
        sticky_next = sticky_reg; sat_next = sat_reg; d_next = d_reg;
        dn_next = dn_reg; dn2_next = dn2_reg; t1_next = t1_reg; tmp_next = tmp_reg;
        var_next = var_reg; sd_next = sd_reg; mv_next = mv_reg; out_next = out_reg;
        cmd = '0; ua = 64'd0; ub = 64'd0;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    d_next   = {{32{s_tdata[31]}}, s_tdata} - mean_reg;
                    sat_next = 1'b0;
                    if (cnt_reg == FULL) begin
                        sticky_next = 1'b1;
                        st_next = ST_VAR;
                    end else begin
                        st_next = ST_DIV;
                    end
                    issued_next = 1'b0;
                end
            end
            ST_OUT: begin
                if (!mv_reg) begin
                    out_next = '0;
                    out_next[31:0]    = (n1w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n1w[31:0];
                    out_next[63:32]   = mean_reg[31:0];
                    out_next[126:64]  = var_reg[62:0];
                    out_next[170:127] = sd_reg[43:0];
                    out_next[171]     = (n1w >= 64'd2);
                    out_next[235:172] = m3_reg;
                    out_next[298:236] = m4_reg[62:0];
                    out_next[299]     = sticky_reg;
                    mv_next = 1'b1;
                    st_next = ST_IDLE;
                end
            end
            default: begin
                if (!issued_reg) begin
                    cmd.start = 1'b1;
                    issued_next = 1'b1;
                    cmd.op = oma_pkg::OP_MUL;
                    cmd.shift = FSH;
                    case (st_reg)
                        ST_DIV:  begin cmd.op = oma_pkg::OP_DIV; ua = dmag; ub = nw; end
                        ST_DN2:  begin ua = dn_reg; ub = dn_reg; end
                        ST_DDN:  begin ua = d_reg; ub = dn_reg; end
                        ST_T1:   begin ua = tmp_reg; ub = n1w; cmd.shift = 6'd0; end
                        ST_A1:   begin ua = t1_reg; ub = dn2_reg; end
                        ST_A2:   begin ua = tmp_reg; ub = poly; cmd.shift = 6'd0; end
                        ST_B1:   begin ua = dn2_reg; ub = m2_reg; end
                        ST_B2:   begin ua = tmp_reg; ub = 64'd6; cmd.shift = 6'd0; end
                        ST_C1:   begin ua = dn_reg; ub = m3_reg; end
                        ST_C2:   begin ua = tmp_reg; ub = 64'd0 - 64'd4; cmd.shift = 6'd0; end
                        ST_E1:   begin ua = t1_reg; ub = dn_reg; end
                        ST_E2:   begin ua = tmp_reg; ub = nm2; cmd.shift = 6'd0; end
                        ST_F1:   begin ua = dn_reg; ub = m2_reg; end
                        ST_F2:   begin ua = tmp_reg; ub = 64'd0 - 64'd3; cmd.shift = 6'd0; end
                        ST_VAR:  begin
                            cmd.op = oma_pkg::OP_DIV; ua = m2_reg; ub = n1w - 64'd1;
                            if (n1w < 64'd2) begin
                                cmd.start = 1'b0; var_next = 64'd0; sd_next = 64'd0;
                                st_next = ST_OUT;
                            end
                        end
                        default: begin cmd.op = oma_pkg::OP_ROOT; ua = var_reg; end
                    endcase
                end else if (ustat.done) begin
                    issued_next = 1'b0;
                    if (st_reg != ST_DIV && st_reg != ST_VAR && st_reg != ST_ROOT
                        && ustat.sat) begin
                        sat_next = 1'b1;
                    end
                    st_next = st_reg + 5'd1;
                    case (st_reg)
                        ST_DIV: dn_next = qsigned;
                        ST_DN2: dn2_next = ures;
                        ST_DDN: tmp_next = ures;
                        ST_T1:  t1_next = ures;
                        ST_A1, ST_B1, ST_C1, ST_E1, ST_F1: tmp_next = ures;
                        ST_A2, ST_B2: begin
                            m4_next = sadd_res;
                            if (sadd_sat) sat_next = 1'b1;
                        end
                        ST_C2: begin
                            m4_next = sadd_res[63] ? 64'd0 : sadd_res;
                            if (sadd_sat) sat_next = 1'b1;
                        end
                        ST_E2: begin
                            tmp_next = sadd_res;
                            if (sadd_sat) sat_next = 1'b1;
                        end
                        ST_F2: begin
                            tmp_next = sadd_res;
                            m3_next = sadd_res;
                            if (sadd_sat) sat_next = 1'b1;
                            // M2 update with the old M2, then commit count and mean.
                            m2_next = m2_res[63] ? 64'd0 : m2_res;
                            if (m2_sat) sat_next = 1'b1;
                            if (sat_next || poly_sat) sticky_next = 1'b1;
                            cnt_next = cnt_reg + COUNT_BITS'(1);
                            mean_next = mean_reg + dn_reg;
                        end
                        ST_VAR: var_next = ures;
                        default: begin
                            sd_next = ures;
                            st_next = ST_OUT;
                        end
                    endcase
                    if (st_reg == ST_E2) begin
                        m3_next = sadd_res;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE; issued_reg <= 1'b0; cnt_reg <= '0; mean_reg <= 64'd0;
            m2_reg <= 64'd0; m3_reg <= 64'd0; m4_reg <= 64'd0; sticky_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            st_reg <= st_next; issued_reg <= issued_next; cnt_reg <= cnt_next;
            mean_reg <= mean_next; m2_reg <= m2_next; m3_reg <= m3_next;
            m4_reg <= m4_next; sticky_reg <= sticky_next; mv_reg <= mv_next;
        end
        sat_reg <= sat_next; d_reg <= d_next; dn_reg <= dn_next;
        dn2_reg <= dn2_next; t1_reg <= t1_next; tmp_reg <= tmp_next;
        var_reg <= var_next; sd_reg <= sd_next; out_reg <= out_next;
    end

    assign s_tready = (st_reg == ST_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    a_m2_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !m2_reg[63]) else $error("M2 negative");
    a_m4_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !m4_reg[63]) else $error("M4 negative");
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(sticky_reg) |-> sticky_reg) else $error("sticky flag cleared");
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        ustat.busy |-> !s_tready) else $error("ready while unit busy");

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Online moment accumulator testbench
// Streams signed Q8.24 samples into the block and checks every result beat
// against a bit-exact fixed-point model of the incremental mean, variance,
// deviation and third and fourth moment sums, with saturation and overflow.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct packed {
        logic [3:0]         pad;
        logic               overflow;
        logic [62:0]        m4;
        logic signed [63:0] m3;
        logic               var_ok;
        logic [43:0]        deviation;
        logic [62:0]        variance;
        logic signed [31:0] mean;
        logic [31:0]        count;
    } stats_t;

    localparam logic signed [63:0] WMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int FRAC = 24;

    class moment_scoreboard;
        logic [63:0]        n_seen;
        logic signed [63:0] mean_q;
        logic signed [63:0] m2_q, m3_q, m4_q;
        bit                 sticky;
        bit                 clamped;
        stats_t             pending[$];
        int                 errors;

        function new();
            n_seen = 0; mean_q = 0; m2_q = 0; m3_q = 0; m4_q = 0;
            sticky = 0; errors = 0;
        endfunction

        function logic signed [63:0] mul_shift(logic signed [63:0] a, logic signed [63:0] b,
                                               int sh);
            logic [127:0] p;
            logic [63:0]  ma, mb, m;
            logic         neg;
            neg = a[63] ^ b[63];
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            p = {64'd0, ma} * {64'd0, mb};
            p = p >> sh;
            if (p[127:63] != 0) begin
                m = WMAX;
                clamped = 1;
            end else begin
                m = p[63:0];
            end
            return neg ? -$signed(m) : $signed(m);
        endfunction

        function logic signed [63:0] add_clamp(logic signed [63:0] a, logic signed [63:0] b);
            logic signed [64:0] s;
            s = $signed({a[63], a}) + $signed({b[63], b});
            if (s > $signed({1'b0, WMAX})) begin
                clamped = 1;
                return WMAX;
            end
            if (s < -$signed({1'b0, WMAX})) begin
                clamped = 1;
                return -WMAX;
            end
            return s[63:0];
        endfunction

        function logic [63:0] root_frac(logic [63:0] v);
            logic [127:0] target, sq;
            logic [63:0]  r, c;
            target = {64'd0, v} << FRAC;
            r = 0;
            for (int b = 47; b >= 0; b--) begin
                c = r | (64'd1 << b);
                sq = {64'd0, c} * {64'd0, c};
                if (sq <= target)
                    r = c;
            end
            return r;
        endfunction

        function void note_sample(logic [31:0] raw);
            logic signed [63:0] x, d, dn, dn2, t1, n_s, a, b;
            logic [63:0]        n, poly, v, sd;
            stats_t             e;
            clamped = 0;
            x = $signed(raw);
            if (n_seen >= 64'hFFFF_FFFF) begin
                sticky = 1;
            end else begin
                n = n_seen + 1;
                n_s = $signed(n);
                d = x - mean_q;
                dn = d / n_s;
                dn2 = mul_shift(dn, dn, FRAC);
                t1 = mul_shift(mul_shift(d, dn, FRAC), $signed(n_seen), 0);
                poly = n * n - 3 * n + 3;
                if (poly > WMAX) begin
                    poly = WMAX;
                    clamped = 1;
                end
                mean_q = mean_q + dn;
                a = add_clamp(m4_q, mul_shift(mul_shift(t1, dn2, FRAC), $signed(poly), 0));
                a = add_clamp(a, mul_shift(mul_shift(dn2, m2_q, FRAC), 64'sd6, 0));
                a = add_clamp(a, -mul_shift(mul_shift(dn, m3_q, FRAC), 64'sd4, 0));
                b = add_clamp(m3_q, mul_shift(mul_shift(t1, dn, FRAC), n_s - 2, 0));
                b = add_clamp(b, -mul_shift(mul_shift(dn, m2_q, FRAC), 64'sd3, 0));
                m4_q = a[63] ? 64'sd0 : a;
                m3_q = b;
                a = add_clamp(m2_q, t1);
                m2_q = a[63] ? 64'sd0 : a;
                n_seen = n;
                if (clamped)
                    sticky = 1;
            end
            v = 0;
            sd = 0;
            if (n_seen >= 2) begin
                v = m2_q / (n_seen - 1);
                sd = root_frac(v);
            end
            e = '0;
            e.count = (n_seen > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n_seen[31:0];
            e.mean = mean_q[31:0];
            e.variance = v[62:0];
            e.deviation = sd[43:0];
            e.var_ok = (n_seen >= 2);
            e.m3 = m3_q;
            e.m4 = m4_q[62:0];
            e.overflow = sticky;
            pending.insert(pending.size(), e);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", field, got, want);
            errors++;
        endtask

        task check_result(stats_t r);
            stats_t e;
            if (pending.size() == 0) begin
                report("result beat with no sample outstanding", 64'd0, 64'd0);
                return;
            end
            e = pending.pop_front();
            if (r.count !== e.count) report("count", 64'(r.count), 64'(e.count));
            if (r.mean !== e.mean) report("running_mean", 64'(r.mean), 64'(e.mean));
            if (r.variance !== e.variance)
                report("sample_variance", 64'(r.variance), 64'(e.variance));
            if (r.deviation !== e.deviation)
                report("std_deviation", 64'(r.deviation), 64'(e.deviation));
            if (r.var_ok !== e.var_ok)
                report("variance_valid", 64'(r.var_ok), 64'(e.var_ok));
            if (r.m3 !== e.m3) report("third_moment_sum", r.m3, e.m3);
            if (r.m4 !== e.m4) report("fourth_moment_sum", 64'(r.m4), 64'(e.m4));
            if (r.overflow !== e.overflow)
                report("overflow", 64'(r.overflow), 64'(e.overflow));
            if (r.pad !== e.pad) report("zero fill", 64'(r.pad), 64'(e.pad));
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [31:0]  s_tdata = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [303:0] m_tdata;

    moment_scoreboard scb = new();
    int sender_idle = 0;
    int receiver_idle = 0;

    online_moment_accumulator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            scb.check_result(stats_t'(m_tdata));
        m_tready <= aresetn && ($urandom_range(99) >= receiver_idle);
    end

    task automatic send_sample(logic [31:0] x);
        while ($urandom_range(99) < sender_idle) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= x;
        do @(posedge aclk); while (!s_tready);
        scb.note_sample(x);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (scb.pending.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(3))
            0, 1: return $urandom_range(32'h0200_0000) - 32'h0100_0000;
            2: return $urandom();
            default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(255)
                                              : 32'h8000_0000 + $urandom_range(255);
        endcase
    endfunction

    initial begin
        logic [31:0] directed[$];
        directed = '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF,
            32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0100_0000, 32'hFF00_0000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
            32'hAAAA_AAAA, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (directed[i])
            send_sample(directed[i]);
        drain();
        for (int ph = 0; ph < 3; ph++) begin
            sender_idle = (ph == 0) ? 26 : (ph == 1) ? 47 : 0;
            receiver_idle = (ph == 0) ? 47 : (ph == 1) ? 26 : 0;
            for (int i = 0; i < 630; i++)
                send_sample(random_sample());
            drain();
        end
        repeat (400) @(posedge aclk);
        if (scb.errors == 0 && scb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(12 * 6000000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
